>>> design/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg
// shared constants and types for the sliding window min/max block
// ----------------------------------------------------------------------------
package swmm_pkg;

  // defaults for the top-level parameters
  localparam int unsigned DEF_MAX_WINDOW = 64;
  localparam int unsigned DEF_DATA_WIDTH = 32;

  // fixed field widths
  localparam int unsigned POS_W     = 32;  // sequence positions
  localparam int unsigned WS_W      = 7;   // window_size register
  localparam int unsigned CFG_IDX_W = 1;   // register index
  localparam int unsigned CFG_DAT_W = WS_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FIND_MAX    = 1'b1;

  // status from the sequencer to the top level
  typedef struct packed {
    logic busy;     // an item is being worked on
    logic holding;  // result ready but the output slot is still full
  } swmm_status_t;

endpackage

>>> design/swmm_store.sv
// ----------------------------------------------------------------------------
// swmm_store
// candidate store: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module swmm_store import swmm_pkg::*; #(
  parameter int unsigned MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH,
  localparam int unsigned PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [PTR_W-1:0]      wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_value,
  input  logic [POS_W-1:0]      wr_pos,
  input  logic [PTR_W-1:0]      rd_addr,
  output logic [DATA_WIDTH-1:0] rd_value,
  output logic [POS_W-1:0]      rd_pos
);

  localparam int unsigned WORD_W = DATA_WIDTH + POS_W;

  logic [WORD_W-1:0] mem [MAX_WINDOW];
  logic [WORD_W-1:0] rd_word_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_value, wr_pos};
    end
  end

  always_ff @(posedge clk) begin
    rd_word_r <= mem[rd_addr];
  end

  assign rd_value = rd_word_r[WORD_W-1:POS_W];
  assign rd_pos   = rd_word_r[POS_W-1:0];

endmodule

>>> design/swmm_ctrl.sv
// ----------------------------------------------------------------------------
// swmm_ctrl
// deque sequencer: front expiry, back pruning, push and result
// ----------------------------------------------------------------------------
module swmm_ctrl import swmm_pkg::*; #(
  parameter int unsigned MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH,
  localparam int unsigned PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // item in
  input  logic                  item_take,
  input  logic [DATA_WIDTH-1:0] item_sample,
  input  logic                  item_first,
  // configuration
  input  logic [WS_W-1:0]       window_size,
  input  logic                  find_max,
  // output slot
  input  logic                  out_free,
  // store
  output logic                  st_wr_en,
  output logic [PTR_W-1:0]      st_wr_addr,
  output logic [DATA_WIDTH-1:0] st_wr_value,
  output logic [POS_W-1:0]      st_wr_pos,
  output logic [PTR_W-1:0]      st_rd_addr,
  input  logic [DATA_WIDTH-1:0] st_rd_value,
  input  logic [POS_W-1:0]      st_rd_pos,
  // result
  output logic                  res_valid,
  output logic [DATA_WIDTH-1:0] res_extreme,
  output logic [POS_W-1:0]      res_extreme_position,
  output logic [POS_W-1:0]      res_window_start,
  output swmm_status_t          status
);

  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(MAX_WINDOW - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FRONT,
    ST_BACK
  } state_t;

  function automatic logic [PTR_W-1:0] slot_next(input logic [PTR_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] slot_prev(input logic [PTR_W-1:0] s);
    return (s == '0) ? LAST_SLOT : s - 1'b1;
  endfunction

  state_t                state_r, state_nxt;
  logic [PTR_W-1:0]      head_r, head_nxt;
  logic [PTR_W-1:0]      tail_r, tail_nxt;
  logic [CNT_W-1:0]      occ_r, occ_nxt;
  logic [POS_W-1:0]      count_r, count_nxt;
  logic                  wrapped_r, wrapped_nxt;
  logic [DATA_WIDTH-1:0] samp_r, samp_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0] hv_r, hv_nxt;
  logic [POS_W-1:0]      hp_r, hp_nxt;

  logic [POS_W-1:0] w_full;
  logic [CNT_W-1:0] w;
  logic             front_pop;
  logic             back_pop;
  logic             useless;
  logic [POS_W-1:0] pos_inc;
  logic             emit;
  logic             hold;

  // effective window: zero reads as one, saturate at the store depth
  always_comb begin
    if (window_size == '0) begin
      w_full = POS_W'(1);
    end else if (POS_W'(window_size) > POS_W'(MAX_WINDOW)) begin
      w_full = POS_W'(MAX_WINDOW);
    end else begin
      w_full = POS_W'(window_size);
    end
  end
  assign w = w_full[CNT_W-1:0];

  assign front_pop = (occ_r != '0) && ((pos_r - st_rd_pos) >= POS_W'(w));
  assign useless   = find_max ? ($signed(st_rd_value) <= $signed(samp_r))
                              : ($signed(st_rd_value) >= $signed(samp_r));
  assign back_pop  = (occ_r != '0) && useless;
  assign pos_inc   = pos_r + 1'b1;
  assign emit      = wrapped_r || (pos_inc == '0) || (pos_inc >= POS_W'(w));
  assign hold      = emit && !out_free;

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    occ_nxt     = occ_r;
    count_nxt   = count_r;
    wrapped_nxt = wrapped_r;
    samp_nxt    = samp_r;
    pos_nxt     = pos_r;
    hv_nxt      = hv_r;
    hp_nxt      = hp_r;
    st_wr_en    = 1'b0;
    st_rd_addr  = head_r;
    res_valid   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (item_take) begin
          samp_nxt = item_sample;
          if (item_first) begin
            head_nxt    = '0;
            tail_nxt    = '0;
            occ_nxt     = '0;
            count_nxt   = '0;
            wrapped_nxt = 1'b0;
            pos_nxt     = '0;
          end else begin
            pos_nxt = count_r;
          end
          state_nxt = ST_FRONT;
        end
      end
      ST_FRONT: begin
        if (front_pop) begin
          head_nxt   = slot_next(head_r);
          occ_nxt    = occ_r - 1'b1;
          st_rd_addr = slot_next(head_r);
        end else begin
          // head survives: keep it for the result
          hv_nxt     = st_rd_value;
          hp_nxt     = st_rd_pos;
          st_rd_addr = slot_prev(tail_r);
          state_nxt  = ST_BACK;
        end
      end
      ST_BACK: begin
        if (back_pop) begin
          tail_nxt   = slot_prev(tail_r);
          occ_nxt    = occ_r - 1'b1;
          st_rd_addr = slot_prev(slot_prev(tail_r));
        end else if (hold) begin
          st_rd_addr = slot_prev(tail_r);
        end else begin
          st_wr_en    = 1'b1;
          tail_nxt    = slot_next(tail_r);
          occ_nxt     = occ_r + 1'b1;
          count_nxt   = pos_inc;
          wrapped_nxt = wrapped_r || (pos_inc == '0);
          res_valid   = emit;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign st_wr_addr  = tail_r;
  assign st_wr_value = samp_r;
  assign st_wr_pos   = pos_r;

  // an empty deque before the push means the new sample is its own extreme
  assign res_extreme          = (occ_r != '0) ? hv_r : samp_r;
  assign res_extreme_position = (occ_r != '0) ? hp_r : pos_r;
  assign res_window_start     = pos_inc - POS_W'(w);

  assign status.busy    = (state_r != ST_IDLE);
  assign status.holding = (state_r == ST_BACK) && !back_pop && hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      head_r    <= '0;
      tail_r    <= '0;
      occ_r     <= '0;
      count_r   <= '0;
      wrapped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      occ_r     <= occ_nxt;
      count_r   <= count_nxt;
      wrapped_r <= wrapped_nxt;
    end
    samp_r <= samp_nxt;
    pos_r  <= pos_nxt;
    hv_r   <= hv_nxt;
    hp_r   <= hp_nxt;
  end

endmodule

>>> design/sliding_window_min_max.sv
// an accepted sample passes ST_FRONT, which drops expired candidates from
//   the front of the deque, then ST_BACK, which drops dominated ones from the
//   back, waits while the output register is full with a result due, then
//   pushes the sample and loads the result; no new sample is taken before
//   that push; each sample is pushed once and dropped at most once
// reset: synchronous, active low; deque empty, position zero, window_size 1,
//   find_max 0; no clearing pass, the store needs none
// ----------------------------------------------------------------------------
// sliding_window_min_max
// running minimum or maximum over the last window_size samples, kept as a
// monotonic deque of candidates in a single-port-read memory
// ----------------------------------------------------------------------------
module sliding_window_min_max import swmm_pkg::*; #(
  parameter int unsigned MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration writes
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_data,
  // sample beats
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_WIDTH-1:0] in_sample,
  input  logic                  in_first,
  // result beats
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_WIDTH-1:0] out_extreme,
  output logic [POS_W-1:0]      out_extreme_position,
  output logic [POS_W-1:0]      out_window_start
);

  localparam int unsigned PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  // configuration registers
  logic [WS_W-1:0] window_size_r;
  logic            find_max_r;

  // store interface
  logic                  st_wr_en;
  logic [PTR_W-1:0]      st_wr_addr;
  logic [DATA_WIDTH-1:0] st_wr_value;
  logic [POS_W-1:0]      st_wr_pos;
  logic [PTR_W-1:0]      st_rd_addr;
  logic [DATA_WIDTH-1:0] st_rd_value;
  logic [POS_W-1:0]      st_rd_pos;

  // result from the sequencer
  logic                  res_valid;
  logic [DATA_WIDTH-1:0] res_extreme;
  logic [POS_W-1:0]      res_extreme_position;
  logic [POS_W-1:0]      res_window_start;
  swmm_status_t          status;

  // output register
  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_extreme_r;
  logic [POS_W-1:0]      out_extreme_position_r;
  logic [POS_W-1:0]      out_window_start_r;

  logic item_take;
  logic out_free;

  // register writes, unknown indexes fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WS_W'(1);
      find_max_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_WINDOW_SIZE: window_size_r <= cfg_data;
        REG_FIND_MAX:    find_max_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // one sample at a time; the output slot is decoupled by its own register
  assign in_stall  = status.busy;
  assign item_take = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  swmm_store #(
    .MAX_WINDOW (MAX_WINDOW),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk      (clk),
    .wr_en    (st_wr_en),
    .wr_addr  (st_wr_addr),
    .wr_value (st_wr_value),
    .wr_pos   (st_wr_pos),
    .rd_addr  (st_rd_addr),
    .rd_value (st_rd_value),
    .rd_pos   (st_rd_pos)
  );

  swmm_ctrl #(
    .MAX_WINDOW (MAX_WINDOW),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk                  (clk),
    .rst_n                (rst_n),
    .item_take            (item_take),
    .item_sample          (in_sample),
    .item_first           (in_first),
    .window_size          (window_size_r),
    .find_max             (find_max_r),
    .out_free             (out_free),
    .st_wr_en             (st_wr_en),
    .st_wr_addr           (st_wr_addr),
    .st_wr_value          (st_wr_value),
    .st_wr_pos            (st_wr_pos),
    .st_rd_addr           (st_rd_addr),
    .st_rd_value          (st_rd_value),
    .st_rd_pos            (st_rd_pos),
    .res_valid            (res_valid),
    .res_extreme          (res_extreme),
    .res_extreme_position (res_extreme_position),
    .res_window_start     (res_window_start),
    .status               (status)
  );

  // output register: loaded only when the slot is free or being emptied
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid) begin
      out_extreme_r          <= res_extreme;
      out_extreme_position_r <= res_extreme_position;
      out_window_start_r     <= res_window_start;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_extreme          = out_extreme_r;
  assign out_extreme_position = out_extreme_position_r;
  assign out_window_start     = out_window_start_r;

`ifndef ASSERT_OFF
  // a new result never overwrites a beat still waiting downstream
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> out_free)
    else $error("result overwrote a pending output beat");

  // an accepted sample is worked on in the next cycle
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    item_take |=> status.busy)
    else $error("accepted sample not picked up");

  // a result closes the item
  a_result_ends: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> !status.busy)
    else $error("sequencer still busy after its result");

  // waiting for the output slot only happens while that slot is full
  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    status.holding |-> (out_valid_r && out_stall))
    else $error("sequencer held with a free output slot");
`endif

endmodule
